// ===== rtl/core/rkt_pkg.sv =====
// Package for the reference-counted key table: opcodes, status codes,
// sequencer states and size defaults. No dependencies.
`timescale 1ns / 1ps

package rkt_pkg;

   localparam int KEY_W               = 64;
   localparam int OP_W                = 3;
   localparam int STATUS_W            = 2;
   localparam int REF_W               = 16;
   localparam int HALF_W              = 32;
   localparam int DEF_TABLE_ENTRIES   = 64;
   localparam int DEF_COUNT_BITS      = 16;

   typedef enum logic [OP_W-1:0] {
      OP_ACQUIRE    = 3'd0,
      OP_RELEASE    = 3'd1,
      OP_QUERY      = 3'd2,
      OP_INVALIDATE = 3'd3,
      OP_VALIDATE   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_UPDATE
   } state_type;

endpackage

// ===== rtl/core/refcounted_key_table_core.sv =====
// Reference-counted key table: top level with probe sequencer and entry update.
// Depends on rkt_pkg, rkt_ram and rkt_hash_unit.
//
// A request (req_operation, req_key) is taken on a clock edge with start high
// and busy low. busy stays high until the request's result has been written
// back; exactly one result follows each request, shown on the rsp_ ports for a
// single cycle while rsp_strobe is high. The receiver cannot stall, so results
// are never held.
// A request with an unused opcode goes straight to the update state. Every
// other request first forms its home slot (multiply, quotient, remainder),
// then probes the entry memory one slot per cycle: a found key ends the
// probe, while an absent key is answered only once the whole table is
// scanned through the single read port of the entry memory. busy falls the
// cycle the result is shown, so the next request can be taken while it is
// on the ports.
// Reset: after reset is released the block sweeps the entry memory, one
// entry per cycle, clearing the occupied flags; busy stays high until the
// sweep is done.
`timescale 1ns / 1ps

module refcounted_key_table_core #(
   parameter int TABLE_ENTRIES = rkt_pkg::DEF_TABLE_ENTRIES,
   parameter int COUNT_BITS    = rkt_pkg::DEF_COUNT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rkt_pkg::OP_W-1:0]     req_operation,
   input  logic [rkt_pkg::KEY_W-1:0]    req_key,
   output logic                         rsp_strobe,
   output logic [rkt_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_key_valid,
   output logic [rkt_pkg::REF_W-1:0]    rsp_use_count,
   output logic                         rsp_newly_created,
   output logic                         rsp_entry_freed
);
   import rkt_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int ENT_W  = KEY_W + COUNT_BITS + 2;
   localparam int CNT_LO = KEY_W;
   localparam int VLD_B  = KEY_W + COUNT_BITS;
   localparam int OCC_B  = KEY_W + COUNT_BITS + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

   state_type state_ff, state_in;

   logic [OP_W-1:0]       op_ff;
   logic [KEY_W-1:0]      key_ff;
   logic                  accept;

   logic                  hash_go, hash_done;
   logic [HALF_W-1:0]     hash_value;
   logic [IDX_W-1:0]      hash_slot;

   logic [IDX_W-1:0]      clr_addr_ff;
   logic [IDX_W-1:0]      probe_addr_ff, probe_addr_in;
   logic [CNT_W-1:0]      issue_cnt_ff, issue_cnt_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      chk_addr_ff, chk_addr_in;
   logic                  chk_last_ff, chk_last_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_slot_ff, free_slot_in;
   logic [COUNT_BITS-1:0] ent_cnt_ff, ent_cnt_in;
   logic                  ent_vld_ff, ent_vld_in;

   logic                  rd_en;
   logic [ENT_W-1:0]      rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [ENT_W-1:0]      wr_data;
   logic                  hit, probe_end;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_key_valid_ff, rsp_key_valid_in;
   logic [REF_W-1:0]      rsp_use_count_ff, rsp_use_count_in;
   logic                  rsp_created_ff, rsp_created_in;
   logic                  rsp_freed_ff, rsp_freed_in;
   logic [COUNT_BITS-1:0] cnt_new;
   logic [31:0]           cnt_wide;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign hash_value = req_key[KEY_W-1 -: HALF_W] + req_key[HALF_W-1:0];
   assign hash_go    = accept && (req_operation <= OP_W'(OP_VALIDATE));

   rkt_hash_unit #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .go    (hash_go),
      .value (hash_value),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   rkt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (probe_addr_ff),
      .rd_data (rd_data)
   );

   assign hit       = pend_ff && rd_data[OCC_B] && (rd_data[KEY_W-1:0] == key_ff);
   assign probe_end = hit || (pend_ff && chk_last_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_addr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_operation inside {[OP_ACQUIRE:OP_VALIDATE]}) begin
                  state_in = S_HASH;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (probe_end) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // probe bookkeeping
   always_comb begin
      rd_en         = 1'b0;
      probe_addr_in = probe_addr_ff;
      issue_cnt_in  = issue_cnt_ff;
      pend_in       = 1'b0;
      chk_addr_in   = chk_addr_ff;
      chk_last_in   = chk_last_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      ent_cnt_in    = ent_cnt_ff;
      ent_vld_in    = ent_vld_ff;
      case (state_ff)
         S_HASH: begin
            probe_addr_in = hash_slot;
            issue_cnt_in  = '0;
            found_in      = 1'b0;
            free_found_in = 1'b0;
         end
         S_PROBE: begin
            if (issue_cnt_ff < CNT_W'(TABLE_ENTRIES)) begin
               rd_en         = 1'b1;
               pend_in       = 1'b1;
               chk_addr_in   = probe_addr_ff;
               chk_last_in   = (issue_cnt_ff == CNT_W'(TABLE_ENTRIES - 1));
               issue_cnt_in  = issue_cnt_ff + 1'b1;
               probe_addr_in = (probe_addr_ff == LAST_IDX) ? '0 : probe_addr_ff + 1'b1;
            end
            if (pend_ff && !rd_data[OCC_B] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_slot_in  = chk_addr_ff;
            end
            if (hit) begin
               found_in   = 1'b1;
               slot_in    = chk_addr_ff;
               ent_cnt_in = rd_data[CNT_LO +: COUNT_BITS];
               ent_vld_in = rd_data[VLD_B];
            end
         end
         default: begin
         end
      endcase
   end

   // memory write and result
   always_comb begin
      wr_en            = 1'b0;
      wr_addr          = slot_ff;
      wr_data          = {1'b1, ent_vld_ff, ent_cnt_ff, key_ff};
      rsp_strobe_in    = 1'b0;
      rsp_status_in    = ST_OK;
      rsp_key_valid_in = 1'b0;
      rsp_created_in   = 1'b0;
      rsp_freed_in     = 1'b0;
      cnt_new          = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
         end
         S_UPDATE: begin
            rsp_strobe_in = 1'b1;
            case (op_ff)
               OP_ACQUIRE: begin
                  if (found_ff) begin
                     rsp_key_valid_in = ent_vld_ff;
                     if (ent_cnt_ff == COUNT_MAX) begin
                        rsp_status_in = ST_OVERFLOW;
                        cnt_new       = ent_cnt_ff;
                     end else begin
                        cnt_new = ent_cnt_ff + 1'b1;
                        wr_en   = 1'b1;
                        wr_data = {1'b1, ent_vld_ff, cnt_new, key_ff};
                     end
                  end else if (free_found_ff) begin
                     cnt_new          = COUNT_BITS'(1);
                     wr_en            = 1'b1;
                     wr_addr          = free_slot_ff;
                     wr_data          = {1'b1, 1'b1, cnt_new, key_ff};
                     rsp_key_valid_in = 1'b1;
                     rsp_created_in   = 1'b1;
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end
               OP_RELEASE: begin
                  if (!found_ff) begin
                     rsp_status_in = ST_NOT_FOUND;
                  end else if (ent_cnt_ff <= COUNT_BITS'(1)) begin
                     wr_en        = 1'b1;
                     wr_data      = {1'b0, ent_vld_ff, {COUNT_BITS{1'b0}}, key_ff};
                     rsp_freed_in = 1'b1;
                  end else begin
                     cnt_new          = ent_cnt_ff - 1'b1;
                     wr_en            = 1'b1;
                     wr_data          = {1'b1, ent_vld_ff, cnt_new, key_ff};
                     rsp_key_valid_in = ent_vld_ff;
                  end
               end
               OP_QUERY: begin
                  if (found_ff) begin
                     cnt_new          = ent_cnt_ff;
                     rsp_key_valid_in = ent_vld_ff;
                  end else begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               end
               OP_INVALIDATE, OP_VALIDATE: begin
                  if (found_ff) begin
                     cnt_new          = ent_cnt_ff;
                     rsp_key_valid_in = (op_ff == OP_W'(OP_VALIDATE));
                     wr_en            = 1'b1;
                     wr_data          = {1'b1, rsp_key_valid_in, ent_cnt_ff, key_ff};
                  end else begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign cnt_wide         = 32'(cnt_new);
   assign rsp_use_count_in = cnt_wide[REF_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         issue_cnt_ff  <= '0;
         pend_ff       <= 1'b0;
         chk_last_ff   <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         issue_cnt_ff  <= issue_cnt_in;
         pend_ff       <= pend_in;
         chk_last_ff   <= chk_last_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      if (accept) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
      end
      probe_addr_ff    <= probe_addr_in;
      chk_addr_ff      <= chk_addr_in;
      slot_ff          <= slot_in;
      free_slot_ff     <= free_slot_in;
      ent_cnt_ff       <= ent_cnt_in;
      ent_vld_ff       <= ent_vld_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_key_valid_ff <= rsp_key_valid_in;
      rsp_use_count_ff <= rsp_use_count_in;
      rsp_created_ff   <= rsp_created_in;
      rsp_freed_ff     <= rsp_freed_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_key_valid     = rsp_key_valid_ff;
   assign rsp_use_count     = rsp_use_count_ff;
   assign rsp_newly_created = rsp_created_ff;
   assign rsp_entry_freed   = rsp_freed_ff;

   a_strobe_after_update : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_UPDATE))
      else $error("result strobe without a preceding update");

   a_accept_goes_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request taken but block not busy");

   a_write_only_clear_update : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_UPDATE))
      else $error("entry memory written outside clear or update");

   a_created_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_newly_created) |->
         (rsp_status == ST_OK && rsp_key_valid && rsp_use_count == REF_W'(1)))
      else $error("new entry reported with wrong fields");

   a_freed_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_entry_freed) |->
         (rsp_status == ST_OK && !rsp_key_valid && rsp_use_count == '0))
      else $error("freed entry reported with wrong fields");

endmodule

// ===== rtl/core/rkt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/rkt_hash_unit.sv =====
// Home-slot reduction: a 32-bit hash modulo the table size by reciprocal
// multiplication. Depends on rkt_pkg.
`timescale 1ns / 1ps

module rkt_hash_unit #(
   parameter int ENTRIES = rkt_pkg::DEF_TABLE_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [rkt_pkg::HALF_W-1:0] value,
   output logic                       done,
   output logic [$clog2(ENTRIES)-1:0] slot
);
   import rkt_pkg::*;

   localparam int                IDX_W   = $clog2(ENTRIES);
   localparam int                SH2     = IDX_W - 1;
   localparam logic [63:0]       SPAN    = (64'd1 << IDX_W) - 64'(ENTRIES);
   localparam logic [63:0]       MAGIC_W = ((SPAN << HALF_W) / 64'(ENTRIES)) + 64'd1;
   localparam logic [HALF_W-1:0] MAGIC   = HALF_W'(MAGIC_W);
   localparam logic [HALF_W-1:0] DIVISOR = HALF_W'(ENTRIES);

   logic [3:0]          stage_ff, stage_in;
   logic [HALF_W-1:0]   val_ff, val_in;
   logic [2*HALF_W-1:0] prod_ff, prod_in;
   logic [HALF_W-1:0]   quo_ff, quo_in;
   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [HALF_W-1:0]   t1, diff, qprod;

   always_comb begin
      stage_in = {stage_ff[2:0], go};
      val_in   = go ? value : val_ff;
      prod_in  = (2*HALF_W)'(val_ff) * (2*HALF_W)'(MAGIC);
      t1       = prod_ff[2*HALF_W-1 -: HALF_W];
      diff     = val_ff - t1;
      quo_in   = (t1 + (diff >> 1)) >> SH2;
      qprod    = quo_ff * DIVISOR;
      rem_in   = IDX_W'(val_ff - qprod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
      val_ff  <= val_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done = stage_ff[3];
   assign slot = rem_ff;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for refcounted_key_table_core: directed, back-to-back and random requests,
// each reply compared with an in-bench table predictor held in a small scoreboard class.
// Depends on rkt_pkg and the refcounted_key_table_core RTL.
`timescale 1ns / 1ps

module tb_top;
   import rkt_pkg::*;

   localparam int ENTRIES = DEF_TABLE_ENTRIES;
   localparam int CNT_W = DEF_COUNT_BITS;
   localparam int POOL_SIZE = 96;
   localparam int SEG_ITEMS = 317;
   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      status_type status;
      logic key_valid;
      logic [REF_W-1:0] use_count;
      logic newly_created;
      logic entry_freed;
   } table_reply;

   class key_table_scoreboard;
      logic [KEY_W-1:0] slot_key [ENTRIES];
      logic [CNT_W-1:0] slot_count [ENTRIES];
      bit slot_valid [ENTRIES];
      bit slot_used [ENTRIES];
      table_reply expected_replies [$];
      int unsigned errors, checked, created, freed, full_hits, missing_hits, saturated;

      function int unsigned home_of(logic [KEY_W-1:0] key);
         logic [HALF_W-1:0] h;
         h = key[KEY_W-1:HALF_W] + key[HALF_W-1:0];
         return h % ENTRIES;
      endfunction

      function int find_key(logic [KEY_W-1:0] key);
         int unsigned s;
         s = home_of(key);
         for (int n = 0; n < ENTRIES; n++) begin
            if (slot_used[s] && slot_key[s] == key) return s;
            s = (s + 1) % ENTRIES;
         end
         return -1;
      endfunction

      function int first_free(logic [KEY_W-1:0] key);
         int unsigned s;
         s = home_of(key);
         for (int n = 0; n < ENTRIES; n++) begin
            if (!slot_used[s]) return s;
            s = (s + 1) % ENTRIES;
         end
         return -1;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
         table_reply r;
         int slot;
         r = '0;
         if (op <= OP_VALIDATE) begin
            slot = find_key(key);
            if (op == OP_ACQUIRE) begin
               if (slot < 0) begin
                  slot = first_free(key);
                  if (slot < 0) begin
                     r.status = ST_FULL;
                     full_hits++;
                  end else begin
                     slot_used[slot] = 1'b1;
                     slot_key[slot] = key;
                     slot_count[slot] = 1;
                     slot_valid[slot] = 1'b1;
                     r.newly_created = 1'b1;
                     r.key_valid = 1'b1;
                     r.use_count = 1;
                     created++;
                  end
               end else begin
                  if (slot_count[slot] == {CNT_W{1'b1}}) begin
                     r.status = ST_OVERFLOW;
                     saturated++;
                  end else begin
                     slot_count[slot] = slot_count[slot] + 1'b1;
                  end
                  r.key_valid = slot_valid[slot];
                  r.use_count = REF_W'(slot_count[slot]);
               end
            end else if (slot < 0) begin
               r.status = ST_NOT_FOUND;
               missing_hits++;
            end else if (op == OP_RELEASE) begin
               if (slot_count[slot] <= 1) begin
                  slot_count[slot] = '0;
                  slot_used[slot] = 1'b0;
                  r.entry_freed = 1'b1;
                  freed++;
               end else begin
                  slot_count[slot] = slot_count[slot] - 1'b1;
                  r.key_valid = slot_valid[slot];
                  r.use_count = REF_W'(slot_count[slot]);
               end
            end else begin
               if (op == OP_INVALIDATE) slot_valid[slot] = 1'b0;
               else if (op == OP_VALIDATE) slot_valid[slot] = 1'b1;
               r.key_valid = slot_valid[slot];
               r.use_count = REF_W'(slot_count[slot]);
            end
         end
         expected_replies.push_back(r);
      endfunction

      function void flag(string field, logic [63:0] want, logic [63:0] got);
         if (errors < 40)
            $display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
         errors++;
      endfunction

      function void check_reply(table_reply got);
         table_reply want;
         if (expected_replies.size() == 0) begin
            if (errors < 40)
               $display("%0t unexpected reply: expected none actual %0h", $time, got);
            errors++;
            return;
         end
         want = expected_replies.pop_front();
         checked++;
         if (got.status !== want.status) flag("status", want.status, got.status);
         if (got.key_valid !== want.key_valid) flag("key_valid", want.key_valid, got.key_valid);
         if (got.use_count !== want.use_count) flag("use_count", want.use_count, got.use_count);
         if (got.newly_created !== want.newly_created)
            flag("newly_created", want.newly_created, got.newly_created);
         if (got.entry_freed !== want.entry_freed)
            flag("entry_freed", want.entry_freed, got.entry_freed);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [OP_W-1:0] req_operation = '0;
   logic [KEY_W-1:0] req_key = '0;
   logic rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic rsp_key_valid;
   logic [REF_W-1:0] rsp_use_count;
   logic rsp_newly_created;
   logic rsp_entry_freed;

   key_table_scoreboard sb;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   bit idling = 1'b1;
   longint cycles = 0;

   refcounted_key_table_core #(
      .TABLE_ENTRIES(ENTRIES),
      .COUNT_BITS(CNT_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_key(req_key),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_key_valid(rsp_key_valid),
      .rsp_use_count(rsp_use_count),
      .rsp_newly_created(rsp_newly_created),
      .rsp_entry_freed(rsp_entry_freed)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   always @(posedge clock) begin : watch
      table_reply got;
      if (!reset && sb != null) begin
         if (rsp_strobe) begin
            got.status = status_type'(rsp_status);
            got.key_valid = rsp_key_valid;
            got.use_count = rsp_use_count;
            got.newly_created = rsp_newly_created;
            got.entry_freed = rsp_entry_freed;
            sb.check_reply(got);
         end
         if (start && !busy) sb.note_request(req_operation, req_key);
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      int unsigned gap;
      gap = 0;
      if (idling && $urandom_range(0, 99) < 14)
         gap = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 90);
      if (gap != 0) begin
         start <= 1'b0;
         req_operation <= OP_W'($urandom);
         req_key <= {$urandom, $urandom};
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_key <= key;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      logic [OP_W-1:0] op;
      logic [KEY_W-1:0] key;
      logic [31:0] hi, lo;
      int unsigned pick, acq_pct, rel_pct;
      sb = new();
      for (int i = 0; i < POOL_SIZE; i++) begin
         hi = $urandom;
         lo = $urandom;
         if (i % 2 == 0) lo[5:0] = 6'($urandom_range(0, 7) * 8) - hi[5:0];
         key_pool[i] = {hi, lo};
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_ACQUIRE, 64'h0);
      send_request(OP_ACQUIRE, {KEY_W{1'b1}});
      send_request(OP_ACQUIRE, 64'h0);
      send_request(OP_QUERY, {KEY_W{1'b1}});
      send_request(OP_INVALIDATE, {KEY_W{1'b1}});
      send_request(OP_QUERY, {KEY_W{1'b1}});
      send_request(OP_ACQUIRE, {KEY_W{1'b1}});
      send_request(OP_VALIDATE, {KEY_W{1'b1}});
      send_request(OP_RELEASE, 64'h0);
      send_request(OP_RELEASE, 64'h0);
      send_request(OP_RELEASE, 64'h0);
      send_request(OP_QUERY, 64'h0);
      send_request(OP_INVALIDATE, 64'h0);
      send_request(OP_VALIDATE, 64'h0);
      send_request(OP_SPARE_5, {KEY_W{1'b1}});
      send_request(OP_SPARE_6, {$urandom, $urandom});
      send_request(OP_SPARE_7, {$urandom, $urandom});
      send_request(OP_ACQUIRE, 64'h0000_0001_0000_0004);
      send_request(OP_ACQUIRE, 64'h0000_0000_0000_0005);
      send_request(OP_ACQUIRE, 64'h0000_0003_0000_0002);
      send_request(OP_RELEASE, 64'h0000_0001_0000_0004);
      send_request(OP_QUERY, 64'h0000_0003_0000_0002);
      send_request(OP_ACQUIRE, 64'h0000_0000_0000_003F);
      send_request(OP_ACQUIRE, 64'h0000_0010_0000_002F);
      send_request(OP_ACQUIRE, 64'h0000_0001_0000_0004);

      // drive one key up with back-to-back acquires, no idling
      idling = 1'b0;
      for (int i = 0; i < 8; i++)
         send_request(OP_ACQUIRE, 64'h5A5A_0000_0000_0028);
      send_request(OP_RELEASE, 64'h5A5A_0000_0000_0028);
      send_request(OP_ACQUIRE, 64'h5A5A_0000_0000_0028);
      send_request(OP_ACQUIRE, 64'h5A5A_0000_0000_0028);
      send_request(OP_QUERY, 64'h5A5A_0000_0000_0028);

      // alternate fill-heavy and drain-heavy segments
      for (int seg = 0; seg < 6; seg++) begin
         idling = (seg != 2);
         acq_pct = (seg % 2 == 0) ? 55 : 20;
         rel_pct = (seg % 2 == 0) ? 15 : 50;
         for (int i = 0; i < SEG_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < acq_pct) op = OP_ACQUIRE;
            else if (pick < acq_pct + rel_pct) op = OP_RELEASE;
            else if (pick < acq_pct + rel_pct + 8) op = OP_QUERY;
            else if (pick < acq_pct + rel_pct + 16) op = OP_INVALIDATE;
            else if (pick < 96) op = OP_VALIDATE;
            else op = OP_SPARE_5 + OP_W'($urandom_range(0, 2));
            key = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                               : key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(op, key);
         end
      end
      start <= 1'b0;

      while (sb.expected_replies.size() != 0) @(posedge clock);
      repeat (ENTRIES + 20) @(posedge clock);
      $display("summary: %0d replies checked; %0d inserts, %0d frees, %0d saturated acquires",
               sb.checked, sb.created, sb.freed, sb.saturated);
      $display("summary: %0d table-full and %0d missing-key replies, %0d mismatches",
               sb.full_hits, sb.missing_hits, sb.errors);
      if (sb.errors == 0 && sb.expected_replies.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule

// ===== refcounted_key_table_core.f =====
rtl/core/rkt_pkg.sv
rtl/core/rkt_ram.sv
rtl/core/rkt_hash_unit.sv
rtl/core/refcounted_key_table_core.sv
tb/tb_top.sv
